### sv/tsbq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbq_pkg
// Shared types and constants of the two-stage bandpass biquad core.
// ----------------------------------------------------------------------------
package tsbq_pkg;

   localparam int SAMPLE_WIDTH   = 16;
   localparam int SAMPLE_FRAC    = 15;
   localparam int COEF_WIDTH     = 24;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   typedef logic signed [SAMPLE_WIDTH-1:0] tsbq_sample_type;
   typedef logic signed [COEF_WIDTH-1:0]   tsbq_coef_type;
   typedef logic [2:0]                     tsbq_reg_index_type;

   // One stage's coefficient set, Q2.22 at the default fraction width
   typedef struct packed {
      tsbq_coef_type gain;
      tsbq_coef_type fb1;
      tsbq_coef_type fb2;
   } tsbq_coef_set_type;

   // Register indexes (byte address = 4 * index)
   localparam tsbq_reg_index_type REG_STAGE1_GAIN = 3'd0;
   localparam tsbq_reg_index_type REG_STAGE1_FB1  = 3'd1;
   localparam tsbq_reg_index_type REG_STAGE1_FB2  = 3'd2;
   localparam tsbq_reg_index_type REG_STAGE2_GAIN = 3'd3;
   localparam tsbq_reg_index_type REG_STAGE2_FB1  = 3'd4;
   localparam tsbq_reg_index_type REG_STAGE2_FB2  = 3'd5;

   localparam tsbq_sample_type SAMPLE_MAX = 16'sh7FFF;
   localparam tsbq_sample_type SAMPLE_MIN = -16'sh8000;

endpackage

### sv/tsbq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbq_req_if / tsbq_rsp_if
// Valid/ready channels for sample words into and out of the core.
// ----------------------------------------------------------------------------
interface tsbq_req_if;
   import tsbq_pkg::*;

   logic            valid;
   logic            ready;
   tsbq_sample_type sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface tsbq_rsp_if;
   import tsbq_pkg::*;

   logic            valid;
   logic            ready;
   tsbq_sample_type sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

### sv/tsbq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbq_cell
// One direct-form-I bandpass biquad section with its own history and one
// multiplier; three products (gain, fb1, fb2) accumulate in turn.
// ----------------------------------------------------------------------------
module tsbq_cell #(
   parameter int IN_WIDTH       = 16,
   parameter int IN_FRAC        = 15,
   parameter int MID_WIDTH      = 24,
   parameter int COEF_FRAC_BITS = 22
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic signed [IN_WIDTH-1:0]     in_data,
   input  tsbq_pkg::tsbq_coef_set_type    coefs,
   output logic                           out_valid,
   output logic signed [MID_WIDTH-1:0]    out_data
);
   import tsbq_pkg::*;

   localparam int MID_FRAC   = MID_WIDTH - 4;
   localparam int OP_WIDTH   = MID_WIDTH + 1;
   localparam int ALIGN_LSH  = (MID_FRAC >= IN_FRAC) ? MID_FRAC - IN_FRAC : 0;
   localparam int ALIGN_RSH  = (MID_FRAC <  IN_FRAC) ? IN_FRAC - MID_FRAC : 0;
   localparam int PROD_WIDTH = COEF_WIDTH + OP_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH + 2;

   localparam logic [1:0] PH_GAIN = 2'd0;
   localparam logic [1:0] PH_FB1  = 2'd1;
   localparam logic [1:0] PH_FB2  = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS =
      ACC_WIDTH'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_WIDTH-1:0] MID_MAX =
      (ACC_WIDTH'(1) << (MID_WIDTH - 1)) - ACC_WIDTH'(1);
   localparam logic signed [ACC_WIDTH-1:0] MID_MIN = ~MID_MAX;

   logic signed [IN_WIDTH-1:0]   x1_ff, x2_ff;
   logic signed [MID_WIDTH-1:0]  y1_ff, y2_ff;
   logic                         busy_ff;
   logic [1:0]                   phase_ff;
   logic signed [OP_WIDTH-1:0]   op_ff, op_in;
   logic signed [OP_WIDTH-1:0]   in_ext, x2_ext, diff;
   logic signed [COEF_WIDTH-1:0] mul_coef;
   logic signed [OP_WIDTH-1:0]   mul_op;
   logic signed [PROD_WIDTH-1:0] prod_ff, prod_in;
   logic signed [ACC_WIDTH-1:0]  acc_ff, acc_sum, acc_shift;
   logic signed [MID_WIDTH-1:0]  result;
   logic                         out_valid_ff;
   logic signed [MID_WIDTH-1:0]  out_data_ff;

   // Input difference x - x[n-2], aligned to the intermediate fraction
   assign in_ext = OP_WIDTH'(in_data);
   assign x2_ext = OP_WIDTH'(x2_ff);
   assign diff   = in_ext - x2_ext;
   assign op_in  = (diff <<< ALIGN_LSH) >>> ALIGN_RSH;

   always_comb begin
      unique case (phase_ff)
         PH_GAIN: begin
            mul_coef = coefs.gain;
            mul_op   = op_ff;
         end
         PH_FB1: begin
            mul_coef = coefs.fb1;
            mul_op   = OP_WIDTH'(y1_ff);
         end
         PH_FB2: begin
            mul_coef = coefs.fb2;
            mul_op   = OP_WIDTH'(y2_ff);
         end
         PH_DONE: begin
            mul_coef = coefs.gain;
            mul_op   = op_ff;
         end
      endcase
   end

   assign prod_in   = mul_coef * mul_op;
   assign acc_sum   = acc_ff + ACC_WIDTH'(prod_ff);
   assign acc_shift = acc_sum >>> COEF_FRAC_BITS;

   always_comb begin
      priority if (acc_shift > MID_MAX) begin
         result = MID_MAX[MID_WIDTH-1:0];
      end else if (acc_shift < MID_MIN) begin
         result = MID_MIN[MID_WIDTH-1:0];
      end else begin
         result = acc_shift[MID_WIDTH-1:0];
      end
   end

   // Control and history
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= PH_GAIN;
         out_valid_ff <= 1'b0;
         x1_ff        <= '0;
         x2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
      end else begin
         out_valid_ff <= 1'b0;
         if (!busy_ff) begin
            if (in_valid) begin
               busy_ff  <= 1'b1;
               phase_ff <= PH_GAIN;
               x2_ff    <= x1_ff;
               x1_ff    <= in_data;
            end
         end else begin
            phase_ff <= phase_ff + 2'd1;
            if (phase_ff == PH_DONE) begin
               busy_ff      <= 1'b0;
               out_valid_ff <= 1'b1;
               y2_ff        <= y1_ff;
               y1_ff        <= result;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (!busy_ff) begin
         if (in_valid) begin
            op_ff  <= op_in;
            acc_ff <= ROUND_BIAS;
         end
      end else begin
         unique case (phase_ff)
            PH_GAIN: prod_ff <= prod_in;
            PH_FB1, PH_FB2: begin
               prod_ff <= prod_in;
               acc_ff  <= acc_sum;
            end
            PH_DONE: out_data_ff <= result;
         endcase
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

### sv/two_stage_bandpass_biquad_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stage_bandpass_biquad_core
// Two cascaded bandpass biquad cells on Q15 samples, Q15 rounded result.
// ----------------------------------------------------------------------------
//
//   Channel   Kind          Payload              Handshake
//   --------  ------------  -------------------  -----------------------------
//   req_chan  sample in     sample_in  (s16)     valid & ready
//   rsp_chan  sample out    sample_out (s16)     valid & ready, 2-word queue
//   csr_*     APB register  6 x 24-bit coefs     psel & penable & pwrite
//
// Flow: a word accepted on the input passes through stage one, then stage
// two, and its result lands in the output queue; the next word is taken
// only after that, and only while the queue has room. Each cell runs its
// three products through its single multiplier in turn.
// Reset clears the history of both cells, the coefficients and the queue.
// A stalled result sink does not hold the input side until both queue
// entries are full.
//
module two_stage_bandpass_biquad_core #(
   parameter int COEF_FRAC_BITS = 22,
   parameter int MID_WIDTH      = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   tsbq_req_if.sink                            req_chan,
   tsbq_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tsbq_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [tsbq_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [tsbq_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import tsbq_pkg::*;

   localparam int MID_FRAC = MID_WIDTH - 4;
   localparam int OUT_RSH  = (MID_FRAC > SAMPLE_FRAC) ? MID_FRAC - SAMPLE_FRAC : 0;
   localparam int OUT_LSH  = (MID_FRAC <= SAMPLE_FRAC) ? SAMPLE_FRAC - MID_FRAC : 0;
   localparam int ROUND_Q  = (1 << OUT_RSH) >> 1;
   localparam int Q_WIDTH  = MID_WIDTH + 2;

   localparam logic signed [Q_WIDTH-1:0] Q_MAX = Q_WIDTH'(SAMPLE_MAX);
   localparam logic signed [Q_WIDTH-1:0] Q_MIN = Q_WIDTH'(SAMPLE_MIN);

   // ---------------------------------------------------------------- config
   tsbq_coef_set_type  stage1_coefs_ff, stage2_coefs_ff;
   tsbq_reg_index_type csr_index;
   logic               csr_write;

   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_coefs_ff <= '0;
         stage2_coefs_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_STAGE1_GAIN: stage1_coefs_ff.gain <= csr_pwdata[COEF_WIDTH-1:0];
            REG_STAGE1_FB1:  stage1_coefs_ff.fb1  <= csr_pwdata[COEF_WIDTH-1:0];
            REG_STAGE1_FB2:  stage1_coefs_ff.fb2  <= csr_pwdata[COEF_WIDTH-1:0];
            REG_STAGE2_GAIN: stage2_coefs_ff.gain <= csr_pwdata[COEF_WIDTH-1:0];
            REG_STAGE2_FB1:  stage2_coefs_ff.fb1  <= csr_pwdata[COEF_WIDTH-1:0];
            REG_STAGE2_FB2:  stage2_coefs_ff.fb2  <= csr_pwdata[COEF_WIDTH-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // Read back zero-extended
   always_comb begin
      unique case (csr_index)
         REG_STAGE1_GAIN: csr_prdata = CSR_DATA_WIDTH'(unsigned'(stage1_coefs_ff.gain));
         REG_STAGE1_FB1:  csr_prdata = CSR_DATA_WIDTH'(unsigned'(stage1_coefs_ff.fb1));
         REG_STAGE1_FB2:  csr_prdata = CSR_DATA_WIDTH'(unsigned'(stage1_coefs_ff.fb2));
         REG_STAGE2_GAIN: csr_prdata = CSR_DATA_WIDTH'(unsigned'(stage2_coefs_ff.gain));
         REG_STAGE2_FB1:  csr_prdata = CSR_DATA_WIDTH'(unsigned'(stage2_coefs_ff.fb1));
         REG_STAGE2_FB2:  csr_prdata = CSR_DATA_WIDTH'(unsigned'(stage2_coefs_ff.fb2));
         default:         csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------ cell chain
   logic                        busy_ff;
   logic [1:0]                  count_ff;
   logic                        req_take;
   logic                        mid_valid, fin_valid;
   logic signed [MID_WIDTH-1:0] mid_data, fin_data;

   // One word in flight at a time; only take it if the queue can hold it
   assign req_chan.ready = !busy_ff && (count_ff != 2'd2);
   assign req_take       = req_chan.valid && req_chan.ready;

   tsbq_cell #(
      .IN_WIDTH       (SAMPLE_WIDTH),
      .IN_FRAC        (SAMPLE_FRAC),
      .MID_WIDTH      (MID_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_stage1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_take),
      .in_data   (req_chan.sample_in),
      .coefs     (stage1_coefs_ff),
      .out_valid (mid_valid),
      .out_data  (mid_data)
   );

   // Stage two sees the stage-one output already in the intermediate format
   tsbq_cell #(
      .IN_WIDTH       (MID_WIDTH),
      .IN_FRAC        (MID_FRAC),
      .MID_WIDTH      (MID_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_stage2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_data   (mid_data),
      .coefs     (stage2_coefs_ff),
      .out_valid (fin_valid),
      .out_data  (fin_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (req_take) begin
         busy_ff <= 1'b1;
      end else if (fin_valid) begin
         busy_ff <= 1'b0;
      end
   end

   // ------------------------------------------------- round to Q15, saturate
   logic signed [Q_WIDTH-1:0] fin_ext, q_wide;
   tsbq_sample_type           q_sat;

   assign fin_ext = Q_WIDTH'(fin_data);
   assign q_wide  = ((fin_ext + Q_WIDTH'(ROUND_Q)) >>> OUT_RSH) <<< OUT_LSH;

   always_comb begin
      priority if (q_wide > Q_MAX) begin
         q_sat = SAMPLE_MAX;
      end else if (q_wide < Q_MIN) begin
         q_sat = SAMPLE_MIN;
      end else begin
         q_sat = q_wide[SAMPLE_WIDTH-1:0];
      end
   end

   // ---------------------------------------------------- two-word out queue
   tsbq_sample_type queue_ff [2];
   logic            wr_ptr_ff, rd_ptr_ff;
   logic            push, pop;

   assign push = fin_valid;
   assign pop  = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= q_sat;
      end
   end

   assign rsp_chan.valid      = (count_ff != 2'd0);
   assign rsp_chan.sample_out = queue_ff[rd_ptr_ff];

endmodule

### sv/tsbq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbq_port_checks
// Port-level checks of the biquad core, bound to the top level.
// ----------------------------------------------------------------------------
module tsbq_port_checks (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input tsbq_pkg::tsbq_sample_type           rsp_sample_out,
   input logic                                csr_psel,
   input logic                                csr_penable,
   input logic                                csr_pwrite,
   input logic [tsbq_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input logic [tsbq_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   input logic [tsbq_pkg::CSR_DATA_WIDTH-1:0] csr_prdata
);
   import tsbq_pkg::*;

   // Hold a stalled result word
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sample_out))
      else $error("result word changed while stalled");

   // One word in flight: taking a word closes the input for the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again while a word is in flight");

   // A coefficient write reads back on the next cycle
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_paddr[4:2] == REG_STAGE1_GAIN)
      ##1 (csr_paddr[4:2] == REG_STAGE1_GAIN)
      |-> (csr_prdata[COEF_WIDTH-1:0] == $past(csr_pwdata[COEF_WIDTH-1:0])))
      else $error("stage one gain read back differs from write");

endmodule

bind two_stage_bandpass_biquad_core tsbq_port_checks u_tsbq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_sample_out (rsp_chan.sample_out),
   .csr_psel       (csr_psel),
   .csr_penable    (csr_penable),
   .csr_pwrite     (csr_pwrite),
   .csr_paddr      (csr_paddr),
   .csr_pwdata     (csr_pwdata),
   .csr_prdata     (csr_prdata)
);

### tb/tsbq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbq_checker
// Watches the sample channels and the register port of the biquad core,
// predicts every output word from its own copy of the filter state and
// compares it with the word that arrives.
// ----------------------------------------------------------------------------
module tsbq_checker #(
   parameter int COEF_FRAC_BITS = 22,
   parameter int MID_WIDTH      = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   tsbq_req_if                                 req_mon,
   tsbq_rsp_if                                 rsp_mon,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic                                csr_pready,
   input  logic [tsbq_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [tsbq_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output int                                  fail_count,
   output int                                  outstanding,
   output int                                  checked_count
);
   import tsbq_pkg::*;

   localparam int MID_FRAC    = MID_WIDTH - 4;
   localparam int REPORT_MAX  = 10;

   tsbq_coef_set_type stage1_coefs;
   tsbq_coef_set_type stage2_coefs;
   longint            in_hist[2];
   longint            mid_hist[2];
   longint            out_hist[2];
   tsbq_sample_type   expected_samples[$];
   tsbq_sample_type   want_word;
   tsbq_coef_type     coef_word;

   function automatic longint sat_signed(longint v, int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // Divide by 2^COEF_FRAC_BITS, round to nearest, ties toward +infinity
   function automatic longint round_coef(longint acc);
      return (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
   endfunction

   function automatic longint align_diff(longint d);
      if (MID_FRAC >= 15)
         return d <<< (MID_FRAC >= 15 ? MID_FRAC - 15 : 0);
      return d >>> (MID_FRAC < 15 ? 15 - MID_FRAC : 0);
   endfunction

   // Run one word through both cells, advance the history, return Q15
   function automatic tsbq_sample_type filter_next_sample(tsbq_sample_type x_in);
      longint x;
      longint mid;
      longint outv;
      longint q;
      int     s;
      x = x_in;
      mid = round_coef(longint'($signed(stage1_coefs.gain)) * align_diff(x - in_hist[1])
                     + longint'($signed(stage1_coefs.fb1)) * mid_hist[0]
                     + longint'($signed(stage1_coefs.fb2)) * mid_hist[1]);
      mid = sat_signed(mid, MID_WIDTH);
      outv = round_coef(longint'($signed(stage2_coefs.gain)) * (mid - mid_hist[1])
                      + longint'($signed(stage2_coefs.fb1)) * out_hist[0]
                      + longint'($signed(stage2_coefs.fb2)) * out_hist[1]);
      outv = sat_signed(outv, MID_WIDTH);
      in_hist[1]  = in_hist[0];
      in_hist[0]  = x;
      mid_hist[1] = mid_hist[0];
      mid_hist[0] = mid;
      out_hist[1] = out_hist[0];
      out_hist[0] = outv;
      if (MID_FRAC > 15) begin
         s = MID_FRAC > 15 ? MID_FRAC - 15 : 1;
         q = (outv + (longint'(1) <<< (s - 1))) >>> s;
      end else begin
         q = outv <<< (MID_FRAC <= 15 ? 15 - MID_FRAC : 0);
      end
      q = sat_signed(q, SAMPLE_WIDTH);
      return q[SAMPLE_WIDTH-1:0];
   endfunction

   task automatic report_mismatch(string what, tsbq_sample_type want, tsbq_sample_type got);
      fail_count = fail_count + 1;
      if (fail_count <= REPORT_MAX)
         $display("mismatch (%s) at output word %0d: expected sample_out %0d, got %0d",
                  what, checked_count, want, got);
   endtask

   initial begin
      fail_count    = 0;
      outstanding   = 0;
      checked_count = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         stage1_coefs = '0;
         stage2_coefs = '0;
         for (int i = 0; i < 2; i++) begin
            in_hist[i]  = 0;
            mid_hist[i] = 0;
            out_hist[i] = 0;
         end
         expected_samples.delete();
      end else begin
         // Register write: low 24 bits only, unknown indexes dropped
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            coef_word = csr_pwdata[COEF_WIDTH-1:0];
            case (tsbq_reg_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]))
               REG_STAGE1_GAIN: stage1_coefs.gain = coef_word;
               REG_STAGE1_FB1:  stage1_coefs.fb1  = coef_word;
               REG_STAGE1_FB2:  stage1_coefs.fb2  = coef_word;
               REG_STAGE2_GAIN: stage2_coefs.gain = coef_word;
               REG_STAGE2_FB1:  stage2_coefs.fb1  = coef_word;
               REG_STAGE2_FB2:  stage2_coefs.fb2  = coef_word;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("unexpected word", '0, rsp_mon.sample_out);
            end else begin
               want_word = expected_samples.pop_front();
               if (want_word !== rsp_mon.sample_out)
                  report_mismatch("sample_out", want_word, rsp_mon.sample_out);
            end
            checked_count = checked_count + 1;
         end
         if (req_mon.valid && req_mon.ready)
            expected_samples.push_back(filter_next_sample(req_mon.sample_in));
      end
      outstanding = expected_samples.size();
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the two-stage bandpass biquad core. Programs the
// six coefficients over the register port between phases, streams Q15
// sample words under four pacing modes, and leaves checking to tsbq_checker.
// ----------------------------------------------------------------------------
module testbench;
   import tsbq_pkg::*;

   localparam int CLOCK_HALF     = 4;
   localparam int RESET_CYCLES   = 7;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_COUNT    = 12;
   localparam int PHASE_WORDS    = 96;
   localparam int SETTLE_CYCLES  = 32;

   // Indexes past the register file; writes to them must change nothing
   localparam tsbq_reg_index_type REG_UNUSED_LO = 3'd6;
   localparam tsbq_reg_index_type REG_UNUSED_HI = 3'd7;

   // Pacing modes of a phase
   typedef enum int {
      PACE_FREE,
      PACE_SEND_IDLE,
      PACE_RECV_STALL,
      PACE_BOTH
   } pace_mode_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   int fail_count;
   int outstanding;
   int checked_count;
   int send_idle_pct;
   int recv_stall_pct;
   int stall_cycles;
   int settings_used;
   int pause_at;
   int total_fail;

   tsbq_sample_type   last_word;
   tsbq_coef_set_type stage1_set;
   tsbq_coef_set_type stage2_set;

   // Formant pair near 800 Hz and 2 kHz at 44.1 kHz, Q = 5, Q2.22
   localparam tsbq_coef_set_type FORMANT_LO = '{24'sd47161, 24'sd8240540, -24'sd4099973};
   localparam tsbq_coef_set_type FORMANT_HI = '{24'sd114682, 24'sd7830195, -24'sd3964942};
   localparam tsbq_coef_set_type ALL_MAX    = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF};
   localparam tsbq_coef_set_type ALL_MIN    = '{-24'sh800000, -24'sh800000, -24'sh800000};

   // Directed words: impulses, full-scale swings and steps, sign edges
   tsbq_sample_type directed_words[$] = '{
      SAMPLE_MAX, 16'sd0, 16'sd0, 16'sd0, SAMPLE_MIN, 16'sd0, -16'sd1, 16'sd1,
      SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
      SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 16'sd0,
      16'sh5555, -16'sh2AAB
   };

   tsbq_req_if req_chan ();
   tsbq_rsp_if rsp_chan ();

   two_stage_bandpass_biquad_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tsbq_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .checked_count (checked_count)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // Result sink: drop ready at random in the stall share of cycles
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Watchdog: count cycles in which no word and no register write moves
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_psel && csr_penable))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no traffic for %0d cycles, %0d words still expected",
                  stall_cycles, outstanding);
         $display("testbench: FAIL");
         $finish;
      end
   end

   // One APB write: setup cycle, access cycle, then a quiet gap so the
   // next setup never lands in the step that lowers psel.
   task automatic csr_write(tsbq_reg_index_type index, logic [CSR_DATA_WIDTH-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Program both cells; garbage rides in the upper bits and the two
   // unused indexes get random data that must be dropped.
   task automatic write_coefs(tsbq_coef_set_type s1, tsbq_coef_set_type s2);
      csr_write(REG_STAGE1_GAIN, {8'($urandom), s1.gain});
      csr_write(REG_STAGE1_FB1,  {8'($urandom), s1.fb1});
      csr_write(REG_STAGE1_FB2,  {8'($urandom), s1.fb2});
      csr_write(REG_UNUSED_LO,   $urandom);
      csr_write(REG_STAGE2_GAIN, {8'($urandom), s2.gain});
      csr_write(REG_STAGE2_FB1,  {8'($urandom), s2.fb1});
      csr_write(REG_STAGE2_FB2,  {8'($urandom), s2.fb2});
      csr_write(REG_UNUSED_HI,   $urandom);
      settings_used = settings_used + 1;
   endtask

   // Offer one word, idling first at the sender's rate; hold valid until
   // accepted and return at the next falling edge.
   task automatic send_sample(tsbq_sample_type s);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.sample_in <= s;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Hold the sender until every expected word has come back
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Random word: full-scale edges, small values, held steps, full range
   function automatic tsbq_sample_type next_stimulus_word();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 10)
         last_word = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      else if (kind < 30)
         last_word = $signed(16'($urandom_range(0, 511))) - 16'sd256;
      else if (kind < 50)
         last_word = last_word;
      else
         last_word = 16'($urandom);
      return last_word;
   endfunction

   function automatic tsbq_coef_set_type random_coefs();
      tsbq_coef_set_type c;
      c.gain = 24'($urandom);
      c.fb1  = 24'($urandom);
      c.fb2  = 24'($urandom);
      return c;
   endfunction

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.sample_in = '0;
      rsp_chan.ready     = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      stall_cycles       = 0;
      settings_used      = 0;
      last_word          = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset coefficients are zero: full-scale words must come out as zero
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      drain_results();

      // Directed words through a realistic formant pair
      write_coefs(FORMANT_LO, FORMANT_HI);
      foreach (directed_words[i]) send_sample(directed_words[i]);
      drain_results();

      // Extreme coefficients drive both cells into saturation
      write_coefs(ALL_MAX, ALL_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      drain_results();

      // Random phases: rotate settings and pacing modes
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase % 7)
            0: begin stage1_set = FORMANT_LO; stage2_set = FORMANT_HI; end
            1: begin stage1_set = ALL_MIN; stage2_set = ALL_MAX; end
            2: begin stage1_set = '0; stage2_set = '0; end
            3: begin
               stage1_set = '{24'sh7FFFFF, 24'sd0, 24'sd0};
               stage2_set = '{-24'sh800000, -24'sh800000, 24'sh7FFFFF};
            end
            4: begin
               // Unity gain lifts the resonant peak well past full scale
               stage1_set = '{24'sd4194304, FORMANT_LO.fb1, FORMANT_LO.fb2};
               stage2_set = '{24'sd4194304, FORMANT_HI.fb1, FORMANT_HI.fb2};
            end
            default: begin stage1_set = random_coefs(); stage2_set = random_coefs(); end
         endcase
         write_coefs(stage1_set, stage2_set);

         case (pace_mode_type'(phase % 4))
            PACE_FREE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            PACE_SEND_IDLE:  begin send_idle_pct = 57; recv_stall_pct = 0;  end
            PACE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            PACE_BOTH:       begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase

         pause_at = $urandom_range(10, PHASE_WORDS - 10);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // Let the pipeline run dry once per phase without a reprogram
            if (n == pause_at) drain_results();
            send_sample(next_stimulus_word());
         end
         drain_results();
         send_idle_pct  = 0;
         recv_stall_pct = 0;
      end

      // Settle: any stray word shows up in the checker
      req_chan.valid <= 1'b0;
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);

      total_fail = fail_count + outstanding;
      if (outstanding != 0)
         $display("%0d expected words never arrived", outstanding);
      $display("covered %0d output words across %0d coefficient settings,", checked_count,
               settings_used);
      $display("free, sender-idle, sink-stall and mixed pacing, %0d failures", total_fail);
      if (total_fail == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
